>>> hw/rtl/wca_pkg.sv
// ---------------------------------------------------------------------------
// WCA pair force package
// Shared types, constants and register indexes of the pair force accumulator.
// ---------------------------------------------------------------------------
package wca_pkg;

  localparam int unsigned MaxParticlesDef = 1024;
  localparam int unsigned CellsPerSideDef = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] REG_BOX_LENGTH = 2'd0;
  localparam logic [1:0] REG_CELL_WIDTH = 2'd1;
  localparam logic [1:0] REG_CUTOFF_SQ  = 2'd2;

  localparam logic [23:0] BOX_RESET    = 24'd2097152;
  localparam logic [23:0] CELL_RESET   = 24'd131072;
  localparam logic [23:0] CUTOFF_RESET = 24'd82570;
  localparam logic [47:0] NEAR_LIMIT   = 48'd16384;

  typedef struct packed {
    logic [9:0]  self_id;
    logic [4:0]  self_cell_x;
    logic [4:0]  self_cell_y;
    logic [23:0] self_off_x;
    logic [23:0] self_off_y;
    logic [9:0]  other_id;
    logic [4:0]  other_cell_x;
    logic [4:0]  other_cell_y;
    logic [23:0] other_off_x;
    logic [23:0] other_off_y;
    logic        last_neighbour;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]         particle;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               saturated;
  } out_beat_t;

  // Classified pair handed from the front to the back.
  typedef struct packed {
    logic               keep;
    logic               near;
    logic               last;
    logic [9:0]         particle;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic [47:0]        q;
  } pair_t;

endpackage

>>> hw/rtl/wca_pair_force_accumulator_top.sv
// ---------------------------------------------------------------------------
// WCA pair force accumulator
// Sums the repulsive WCA force on a particle over a stream of neighbour pairs.
// ---------------------------------------------------------------------------
// A pair passes through the front states idle, square and done. A pair in range
// then runs in the back through the bit-serial reciprocal, which yields 41
// quotient bits, followed by the multiply chain; skipped and close pairs go
// straight to the accumulate state. A two-entry queue lets the front take the next pair meanwhile.
// The result is held in an output register until it is popped.
module wca_pair_force_accumulator_top #(
  parameter int unsigned MAX_PARTICLES  = wca_pkg::MaxParticlesDef,
  parameter int unsigned CELLS_PER_SIDE = wca_pkg::CellsPerSideDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  wca_pkg::in_beat_t in_beat,
  output logic              empty,
  input  logic              pop,
  output wca_pkg::out_beat_t out_beat,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  import wca_pkg::*;

  logic [23:0] box_r, cell_r, cut_r;
  logic        f_valid, f_ready, f_busy, q_full, q_empty, b_pop, b_valid;
  pair_t       f_pair, q_pair;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r  <= BOX_RESET;
      cell_r <= CELL_RESET;
      cut_r  <= CUTOFF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_LENGTH: box_r  <= cfg_data;
        REG_CELL_WIDTH: cell_r <= cfg_data;
        REG_CUTOFF_SQ:  cut_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full    = f_busy;
  assign f_ready = !q_full;

  wca_front #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .CELLS_PER_SIDE(CELLS_PER_SIDE)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(push), .in_beat(in_beat),
    .box_length(box_r), .cell_width(cell_r), .cutoff_sq(cut_r),
    .out_ready(f_ready), .out_valid(f_valid), .out_pair(f_pair), .busy(f_busy)
  );

  wca_queue #(.DEPTH(QueueDepth)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(f_valid), .push_data(f_pair), .full(q_full),
    .pop(b_pop), .pop_data(q_pair), .empty(q_empty)
  );

  wca_back u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(!q_empty), .in_pair(q_pair), .in_pop(b_pop),
    .out_valid(b_valid), .out_beat(out_beat), .out_pop(pop)
  );

  assign empty = !b_valid;

endmodule

>>> hw/rtl/wca_front.sv
// ---------------------------------------------------------------------------
// WCA pair front
// Rebuilds positions, wraps to the minimum image and classifies each pair.
// ---------------------------------------------------------------------------
module wca_front #(
  parameter int unsigned MAX_PARTICLES  = wca_pkg::MaxParticlesDef,
  parameter int unsigned CELLS_PER_SIDE = wca_pkg::CellsPerSideDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  wca_pkg::in_beat_t in_beat,
  input  logic [23:0]      box_length,
  input  logic [23:0]      cell_width,
  input  logic [23:0]      cutoff_sq,
  input  logic             out_ready,
  output logic             out_valid,
  output wca_pkg::pair_t   out_pair,
  output logic             busy
);
  import wca_pkg::*;

  localparam int unsigned IdW = $clog2(MAX_PARTICLES) + 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SQR  = 3'b010,
    F_DONE = 3'b100
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic               keep_r, keep_nxt;
  logic               last_r, last_nxt;
  logic [9:0]         part_r, part_nxt;
  logic signed [35:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [47:0]        q_r, q_nxt;
  logic [33:0]        ax, ay;
  logic [67:0]        ssum;
  logic [4:0]         cell_mod [32];

  for (genvar g = 0; g < 32; g++) begin : g_mod
    assign cell_mod[g] = 5'(g % CELLS_PER_SIDE);
  end

  function automatic logic [35:0] abs_pos(input logic [4:0] c, input logic [23:0] off,
                                         input logic [23:0] cw);
    logic [35:0] p;
    p = 36'(c) * 36'(cw) + 36'(off);
    return p;
  endfunction

  function automatic logic signed [35:0] wrap(input logic signed [35:0] d,
                                             input logic [23:0] len);
    logic signed [36:0] d2, l;
    logic signed [35:0] r;
    d2 = 37'(d) <<< 1;
    l  = 37'(len);
    r  = d;
    if (len != 24'd0) begin
      if (d2 > l) r = d - 36'(len);
      else if (d2 < -l) r = d + 36'(len);
    end
    return r;
  endfunction

  assign ax   = dx_r[35] ? 34'(-dx_r) : 34'(dx_r);
  assign ay   = dy_r[35] ? 34'(-dy_r) : 34'(dy_r);
  assign ssum = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);

  always_comb begin
    state_nxt = state_r;
    keep_nxt  = keep_r;
    last_nxt  = last_r;
    part_nxt  = part_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    q_nxt     = q_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          dx_nxt = wrap(abs_pos(cell_mod[in_beat.self_cell_x], in_beat.self_off_x, cell_width)
                      - abs_pos(cell_mod[in_beat.other_cell_x], in_beat.other_off_x,
                                cell_width),
                      box_length);
          dy_nxt = wrap(abs_pos(cell_mod[in_beat.self_cell_y], in_beat.self_off_y, cell_width)
                      - abs_pos(cell_mod[in_beat.other_cell_y], in_beat.other_off_y,
                                cell_width),
                      box_length);
          keep_nxt = (in_beat.self_id != in_beat.other_id)
                  && (IdW'(in_beat.self_id) < IdW'(MAX_PARTICLES))
                  && (IdW'(in_beat.other_id) < IdW'(MAX_PARTICLES));
          last_nxt  = in_beat.last_neighbour;
          part_nxt  = in_beat.self_id;
          state_nxt = F_SQR;
        end
      end
      F_SQR: begin
        q_nxt     = ssum[63:16];
        keep_nxt  = keep_r && (ssum[67:16] <= 52'(cutoff_sq));
        state_nxt = F_DONE;
      end
      F_DONE: begin
        if (out_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    keep_r <= keep_nxt;
    last_r <= last_nxt;
    part_r <= part_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    q_r    <= q_nxt;
  end

  assign out_valid = (state_r == F_DONE);
  assign busy      = (state_r != F_IDLE);
  always_comb begin
    out_pair.keep     = keep_r;
    out_pair.near     = (q_r <= NEAR_LIMIT);
    out_pair.last     = last_r;
    out_pair.particle = part_r;
    out_pair.dx       = dx_r;
    out_pair.dy       = dy_r;
    out_pair.q        = q_r;
  end
endmodule

>>> hw/rtl/wca_queue.sv
// ---------------------------------------------------------------------------
// WCA pair queue
// Short queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module wca_queue #(
  parameter int unsigned DEPTH = wca_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wca_pkg::pair_t push_data,
  output logic           full,
  input  logic           pop,
  output wca_pkg::pair_t pop_data,
  output logic           empty
);
  import wca_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pair_t          mem [DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (do_push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem[wp_r] <= push_data;
  end
endmodule

>>> hw/rtl/wca_back.sv
// ---------------------------------------------------------------------------
// WCA pair back
// Iterative reciprocal, power chain, force terms and saturating sums.
// ---------------------------------------------------------------------------
module wca_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  wca_pkg::pair_t    in_pair,
  output logic              in_pop,
  output logic              out_valid,
  output wca_pkg::out_beat_t out_beat,
  input  logic              out_pop
);
  import wca_pkg::*;

  typedef enum logic [9:0] {
    B_IDLE = 10'b0000000001,
    B_DIV  = 10'b0000000010,
    B_W2   = 10'b0000000100,
    B_W3   = 10'b0000001000,
    B_W4   = 10'b0000010000,
    B_CM   = 10'b0000100000,
    B_CF   = 10'b0001000000,
    B_TX   = 10'b0010000000,
    B_ACC  = 10'b0100000000,
    B_OUT  = 10'b1000000000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  pair_t              p_r, p_nxt;
  logic [40:0]        num_r, num_nxt;
  logic [40:0]        quo_r, quo_nxt;
  logic [48:0]        rem_r, rem_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [27:0]        w2_r, w2_nxt;
  logic [29:0]        w3_r, w3_nxt;
  logic [31:0]        w4_r, w4_nxt;
  logic [38:0]        cm_r, cm_nxt;
  logic               cneg_r, cneg_nxt;
  logic [30:0]        tmag_r, tmag_nxt;
  logic signed [32:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [31:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic               clip_r, clip_nxt;
  out_beat_t          res_r, res_nxt;
  logic               res_v_r, res_v_nxt;
  logic [48:0]        trial;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [30:0]        w3x2;

  function automatic logic signed [32:0] term(input logic [35:0] cmag, input logic cneg,
                                             input logic signed [35:0] d,
                                             output logic clip);
    logic        dneg;
    logic [20:0] dmag;
    logic [56:0] p;
    logic signed [32:0] r;
    dneg = d[35];
    dmag = dneg ? 21'(-d) : 21'(d);
    p    = (cmag * dmag) >> 16;
    clip = 1'b0;
    if ((cneg != dneg) && p != '0) begin
      if (p > 57'd2147483648) begin
        clip = 1'b1;
        p = 57'd2147483648;
      end
      r = -33'(p[32:0]);
    end else begin
      if (p > 57'd2147483647) begin
        clip = 1'b1;
        p = 57'd2147483647;
      end
      r = 33'(p[32:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [31:0] a,
                                            input logic signed [32:0] t,
                                            output logic clip);
    logic signed [33:0] s;
    s = 34'(a) + 34'(t);
    clip = 1'b0;
    if (s > 34'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end
    if (s < -34'sd2147483648) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  assign trial = {rem_r[47:0], num_r[40]} - 49'(p_r.q);
  assign w3x2  = {w3_r, 1'b0};
  assign mul_p = mul_a * mul_b;

  // One shared multiplier serves the power chain; the reciprocal fits in 26 bits.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      B_W2: begin
        mul_a = 32'(quo_r[25:0]);
        mul_b = 32'(quo_r[25:0]);
      end
      B_W3: begin
        mul_a = 32'(w2_r);
        mul_b = 32'(quo_r[25:0]);
      end
      B_W4: begin
        mul_a = 32'(w2_r);
        mul_b = 32'(w2_r);
      end
      B_CM: begin
        mul_a = w4_r;
        mul_b = 32'(tmag_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    logic c1, c2;
    state_nxt = state_r;
    p_nxt     = p_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    w2_nxt    = w2_r;
    w3_nxt    = w3_r;
    w4_nxt    = w4_r;
    cm_nxt    = cm_r;
    cneg_nxt  = cneg_r;
    tmag_nxt  = tmag_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    clip_nxt  = clip_r;
    res_nxt   = res_r;
    res_v_nxt = res_v_r;
    in_pop    = 1'b0;
    c1        = 1'b0;
    c2        = 1'b0;
    if (out_pop && res_v_r) res_v_nxt = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (in_valid) begin
          in_pop = 1'b1;
          p_nxt  = in_pair;
          if (!in_pair.keep) begin
            tx_nxt = '0;
            ty_nxt = '0;
            state_nxt = B_ACC;
          end else if (in_pair.near) begin
            clip_nxt = 1'b1;
            tx_nxt = (in_pair.dx == '0) ? 33'sd0 :
                     (in_pair.dx[35] ? -33'sd2147483648 : 33'sd2147483647);
            ty_nxt = (in_pair.dy == '0) ? 33'sd0 :
                     (in_pair.dy[35] ? -33'sd2147483648 : 33'sd2147483647);
            state_nxt = B_ACC;
          end else begin
            num_nxt   = 41'h100_0000_0000;
            rem_nxt   = '0;
            quo_nxt   = '0;
            cnt_nxt   = 6'd41;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (!trial[48]) begin
          rem_nxt = trial;
          quo_nxt = {quo_r[39:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[47:0], num_r[40]};
          quo_nxt = {quo_r[39:0], 1'b0};
        end
        num_nxt = {num_r[39:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = B_W2;
      end
      B_W2: begin
        w2_nxt    = mul_p[51:24];
        state_nxt = B_W3;
      end
      B_W3: begin
        w3_nxt    = mul_p[53:24];
        state_nxt = B_W4;
      end
      B_W4: begin
        w4_nxt = mul_p[55:24];
        if (w3x2 >= 31'd16777216) begin
          tmag_nxt = w3x2 - 31'd16777216;
          cneg_nxt = 1'b0;
        end else begin
          tmag_nxt = 31'd16777216 - w3x2;
          cneg_nxt = 1'b1;
        end
        state_nxt = B_CM;
      end
      B_CM: begin
        cm_nxt    = mul_p[62:24];
        state_nxt = B_CF;
      end
      B_CF: begin
        cm_nxt    = 39'((44'(cm_r) * 44'd24) >> 8);
        state_nxt = B_TX;
      end
      B_TX: begin
        tx_nxt = term(cm_r[35:0], cneg_r, p_r.dx, c1);
        ty_nxt = term(cm_r[35:0], cneg_r, p_r.dy, c2);
        if (c1 || c2) clip_nxt = 1'b1;
        state_nxt = B_ACC;
      end
      B_ACC: begin
        sx_nxt = sat(sx_r, tx_r, c1);
        sy_nxt = sat(sy_r, ty_r, c2);
        if (c1 || c2) clip_nxt = 1'b1;
        if (p_r.last) begin
          state_nxt = B_OUT;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_OUT: begin
        if (!res_v_r || out_pop) begin
          res_nxt.particle  = p_r.particle;
          res_nxt.force_x   = sx_r;
          res_nxt.force_y   = sy_r;
          res_nxt.saturated = clip_r;
          res_v_nxt = 1'b1;
          sx_nxt    = '0;
          sy_nxt    = '0;
          clip_nxt  = 1'b0;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      sx_r    <= '0;
      sy_r    <= '0;
      clip_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      clip_r  <= clip_nxt;
      res_v_r <= res_v_nxt;
    end
    p_r    <= p_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    w2_r   <= w2_nxt;
    w3_r   <= w3_nxt;
    w4_r   <= w4_nxt;
    cm_r   <= cm_nxt;
    cneg_r <= cneg_nxt;
    tmag_r <= tmag_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = res_v_r;
  assign out_beat  = res_r;
endmodule
